>>> hdl/cmf_pkg.sv
// Shared types and constants of the CSV column match filter.
`default_nettype none

package cmf_pkg;

    localparam int TEXT_W      = 8;
    localparam int LINE_W      = 24;
    localparam int COLSEL_W    = 7;
    localparam int KEYLEN_W    = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int FIELD_POS_W = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_SELECT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_HIGH = 2'd3;

    localparam logic [TEXT_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [TEXT_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = QPTR_W + 1;

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_COMMA   = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TEXT_W-1:0] text;
    } token_t;

    typedef struct packed {
        logic                full;
        logic                not_empty;
        logic [QCOUNT_W-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic [LINE_W-1:0]   line_number;
        logic                is_header;
        logic [COLSEL_W-1:0] column_total;
        logic                column_out_of_range;
        logic                field_matches;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/cmf_front.sv
// Front end: accepts stream words and classifies each into a token for the queue.
`default_nettype none

module cmf_front
(
    input  wire logic                        in_valid,
    input  wire logic [cmf_pkg::TEXT_W-1:0]  text_byte,
    input  wire logic                        end_of_stream,
    input  wire cmf_pkg::queue_status_t      q_status,
    output logic                             in_stall,
    output logic                             push,
    output cmf_pkg::token_t                  token
);

    always_comb
    begin
        token.text = text_byte;
        priority if (end_of_stream)
            token.kind = cmf_pkg::KIND_END;
        else if (text_byte == cmf_pkg::CHAR_NEWLINE)
            token.kind = cmf_pkg::KIND_NEWLINE;
        else if (text_byte == cmf_pkg::CHAR_COMMA)
            token.kind = cmf_pkg::KIND_COMMA;
        else
            token.kind = cmf_pkg::KIND_TEXT;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

`default_nettype wire

>>> hdl/cmf_queue.sv
// Short token queue between the front end and the line processor.
`default_nettype none

module cmf_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cmf_pkg::token_t  push_token,
    input  wire logic             pop,
    output cmf_pkg::token_t       head_token,
    output cmf_pkg::queue_status_t status
);

    cmf_pkg::token_t                 slots_reg [cmf_pkg::QUEUE_DEPTH];
    logic [cmf_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [cmf_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [cmf_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [cmf_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [cmf_pkg::QCOUNT_W-1:0]    count_reg;
    logic [cmf_pkg::QCOUNT_W-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_token;
        end
    end

    assign head_token       = slots_reg[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == cmf_pkg::QCOUNT_W'(cmf_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> hdl/cmf_back.sv
// Back end: per-line parsing, key comparison and the registered result word.
`default_nettype none

module cmf_back
#(
    parameter int MAX_COLUMNS = 64,
    parameter int KEY_LIMIT   = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cmf_pkg::queue_status_t        q_status,
    input  wire cmf_pkg::token_t               token,
    input  wire logic [cmf_pkg::COLSEL_W-1:0]  column_select,
    input  wire logic [cmf_pkg::KEYLEN_W-1:0]  key_length,
    input  wire logic [2*cmf_pkg::CFG_DATA_W-1:0] key_bytes,
    input  wire logic                          out_stall,
    output logic                               pop,
    output logic                               out_valid,
    output cmf_pkg::result_t                   result
);

    localparam int CC_W  = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam int TOT_W = CC_W + 1;
    localparam int CMP_W = (TOT_W > cmf_pkg::COLSEL_W) ? TOT_W : cmf_pkg::COLSEL_W;
    localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_COLUMNS - 1);
    localparam logic [cmf_pkg::FIELD_POS_W-1:0] POS_MAX = '1;
    localparam logic [cmf_pkg::LINE_W-1:0] LINE_MAX = '1;

    logic                                header_done_reg, header_done_next;
    logic                                stopped_reg, stopped_next;
    logic [CC_W-1:0]                     comma_count_reg, comma_count_next;
    logic [cmf_pkg::FIELD_POS_W-1:0]     field_position_reg, field_position_next;
    logic                                field_seen_reg, field_seen_next;
    logic                                field_closed_reg, field_closed_next;
    logic                                still_equal_reg, still_equal_next;
    logic                                line_has_bytes_reg, line_has_bytes_next;
    logic [cmf_pkg::LINE_W-1:0]          data_line_count_reg, data_line_count_next;
    logic                                out_valid_reg, out_valid_next;
    cmf_pkg::result_t                    result_reg, result_next;

    logic                                close_line;
    logic [TOT_W-1:0]                    total;
    logic [CMP_W-1:0]                    total_ext;
    logic [CMP_W-1:0]                    select_ext;
    logic                                column_hit;
    logic [cmf_pkg::KEYLEN_W-1:0]        eff_length;
    logic [cmf_pkg::TEXT_W-1:0]          key_byte;
    logic                                out_of_range;
    logic                                present;

    assign total      = TOT_W'(comma_count_reg) + 1'b1;
    assign total_ext  = CMP_W'(total);
    assign select_ext = CMP_W'(column_select);
    assign column_hit = (total_ext == select_ext);
    assign eff_length = (key_length < cmf_pkg::KEYLEN_W'(KEY_LIMIT))
                        ? key_length : cmf_pkg::KEYLEN_W'(KEY_LIMIT);
    assign key_byte   = key_bytes[{field_position_reg[3:0], 3'b000} +: cmf_pkg::TEXT_W];
    assign out_of_range = (column_select == '0) || (select_ext > total_ext);
    assign present    = field_seen_reg || column_hit;

    assign pop = q_status.not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        header_done_next     = header_done_reg;
        stopped_next         = stopped_reg;
        comma_count_next     = comma_count_reg;
        field_position_next  = field_position_reg;
        field_seen_next      = field_seen_reg;
        field_closed_next    = field_closed_reg;
        still_equal_next     = still_equal_reg;
        line_has_bytes_next  = line_has_bytes_reg;
        data_line_count_next = data_line_count_reg;
        result_next          = result_reg;
        close_line           = 1'b0;
        out_valid_next       = out_valid_reg && out_stall;

        if (pop && !stopped_reg)
        begin
            unique case (token.kind)
                cmf_pkg::KIND_END:
                begin
                    close_line = line_has_bytes_reg;
                end
                cmf_pkg::KIND_NEWLINE:
                begin
                    close_line = 1'b1;
                end
                cmf_pkg::KIND_COMMA:
                begin
                    line_has_bytes_next = 1'b1;
                    if (!header_done_reg || (!field_closed_reg && !column_hit))
                    begin
                        if (comma_count_reg < CC_MAX)
                            comma_count_next = comma_count_reg + 1'b1;
                    end
                    else if (!field_closed_reg)
                    begin
                        field_seen_next   = 1'b1;
                        field_closed_next = 1'b1;
                    end
                end
                cmf_pkg::KIND_TEXT:
                begin
                    line_has_bytes_next = 1'b1;
                    if (header_done_reg && !field_closed_reg && column_hit)
                    begin
                        field_seen_next = 1'b1;
                        if (!((field_position_reg < eff_length) && (key_byte == token.text)))
                            still_equal_next = 1'b0;
                        if (field_position_reg != POS_MAX)
                            field_position_next = field_position_reg + 1'b1;
                    end
                end
            endcase
        end

        if (close_line)
        begin
            out_valid_next = 1'b1;
            if (!header_done_reg)
            begin
                result_next.line_number         = '0;
                result_next.is_header           = 1'b1;
                result_next.column_total        = cmf_pkg::COLSEL_W'(total);
                result_next.column_out_of_range = out_of_range;
                result_next.field_matches       = 1'b0;
                header_done_next                = 1'b1;
                stopped_next                    = out_of_range;
            end
            else
            begin
                if (data_line_count_reg != LINE_MAX)
                    data_line_count_next = data_line_count_reg + 1'b1;
                result_next.line_number         = data_line_count_next;
                result_next.is_header           = 1'b0;
                result_next.column_total        = '0;
                result_next.column_out_of_range = 1'b0;
                result_next.field_matches       = present && still_equal_reg
                                                  && (field_position_reg == eff_length);
            end
            comma_count_next    = '0;
            field_position_next = '0;
            field_seen_next     = 1'b0;
            field_closed_next   = 1'b0;
            still_equal_next    = 1'b1;
            line_has_bytes_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_done_reg     <= 1'b0;
            stopped_reg         <= 1'b0;
            comma_count_reg     <= '0;
            field_position_reg  <= '0;
            field_seen_reg      <= 1'b0;
            field_closed_reg    <= 1'b0;
            still_equal_reg     <= 1'b1;
            line_has_bytes_reg  <= 1'b0;
            data_line_count_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            header_done_reg     <= header_done_next;
            stopped_reg         <= stopped_next;
            comma_count_reg     <= comma_count_next;
            field_position_reg  <= field_position_next;
            field_seen_reg      <= field_seen_next;
            field_closed_reg    <= field_closed_next;
            still_equal_reg     <= still_equal_next;
            line_has_bytes_reg  <= line_has_bytes_next;
            data_line_count_reg <= data_line_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> hdl/csv_column_match_filter.sv
// Top level of the CSV column match filter: configuration registers, front end, queue, back end.
//
// The input channel takes one word per cycle while in_stall is low: a text byte, or an
// end-of-stream mark that carries no byte. The first line is the header; when it closes, one
// result word gives the column count and flags a selected column outside the header; a flagged
// header leaves the block silent until reset. Each later line closed by a newline, or by end of
// stream when the line holds bytes, gives one result word with its line number and whether the
// selected field equals the key. Other input words give no result. A word is accepted when
// in_valid is high and in_stall low; out_valid and out_stall do the same for results. An
// accepted word passes through a four-entry token queue to the line processor, whose result word
// is registered. The line processor, which sets the input rate, handles one token per cycle
// unless a stalled result word holds it. While the receiver stalls a valid result word, the word
// holds, the line processor waits and the queue fills; in_stall rises once the queue is full.
// Reset clears all line state and the queue, and sets column_select and key_length to one and
// the key to zero. Configuration is written through cfg_write, cfg_index and cfg_data while the
// block is idle; the user must keep to this, as the block does not enforce it.
`default_nettype none

module csv_column_match_filter
#(
    parameter int KEY_BYTES   = 16,
    parameter int MAX_COLUMNS = 64
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [cmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [cmf_pkg::TEXT_W-1:0]       text_byte,
    input  wire logic                             end_of_stream,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [cmf_pkg::LINE_W-1:0]            line_number,
    output logic                                  is_header,
    output logic [cmf_pkg::COLSEL_W-1:0]          column_total,
    output logic                                  column_out_of_range,
    output logic                                  field_matches
);

    localparam int KEY_LIMIT = (KEY_BYTES < 16) ? KEY_BYTES : 16;

    logic [cmf_pkg::COLSEL_W-1:0]   column_select_reg;
    logic [cmf_pkg::KEYLEN_W-1:0]   key_length_reg;
    logic [cmf_pkg::CFG_DATA_W-1:0] key_low_reg;
    logic [cmf_pkg::CFG_DATA_W-1:0] key_high_reg;

    cmf_pkg::queue_status_t q_status;
    cmf_pkg::token_t        push_token;
    cmf_pkg::token_t        head_token;
    cmf_pkg::result_t       result;
    logic                   push;
    logic                   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_select_reg <= cmf_pkg::COLSEL_W'(1);
            key_length_reg    <= cmf_pkg::KEYLEN_W'(1);
            key_low_reg       <= '0;
            key_high_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cmf_pkg::REG_COLUMN_SELECT:  column_select_reg <= cfg_data[cmf_pkg::COLSEL_W-1:0];
                cmf_pkg::REG_KEY_LENGTH:     key_length_reg    <= cfg_data[cmf_pkg::KEYLEN_W-1:0];
                cmf_pkg::REG_KEY_BYTES_LOW:  key_low_reg       <= cfg_data;
                cmf_pkg::REG_KEY_BYTES_HIGH: key_high_reg      <= cfg_data;
            endcase
        end
    end

    cmf_front u_front
    (
        .in_valid      (in_valid),
        .text_byte     (text_byte),
        .end_of_stream (end_of_stream),
        .q_status      (q_status),
        .in_stall      (in_stall),
        .push          (push),
        .token         (push_token)
    );

    cmf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .head_token (head_token),
        .status     (q_status)
    );

    cmf_back
    #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .KEY_LIMIT   (KEY_LIMIT)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .token         (head_token),
        .column_select (column_select_reg),
        .key_length    (key_length_reg),
        .key_bytes     ({key_high_reg, key_low_reg}),
        .out_stall     (out_stall),
        .pop           (pop),
        .out_valid     (out_valid),
        .result        (result)
    );

    assign line_number         = result.line_number;
    assign is_header           = result.is_header;
    assign column_total        = result.column_total;
    assign column_out_of_range = result.column_out_of_range;
    assign field_matches       = result.field_matches;

    a_header_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header |-> line_number == '0 && !field_matches)
        else $error("header word carries data line fields");

    a_data_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_header |-> column_total == '0 && !column_out_of_range
                                    && line_number != '0)
        else $error("data line word carries header fields");

    a_silent_after_range_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && is_header && column_out_of_range |=> !out_valid)
        else $error("result word after an out of range header");

    a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty && q_status.count != '0)
        else $error("token taken from an empty queue");

endmodule

`default_nettype wire

>>> test/cmf_result_checker.sv
// Predicts and checks the result words of the CSV column match filter.
`timescale 1ns / 100ps

module cmf_result_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [cmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [cmf_pkg::TEXT_W-1:0]      text_byte,
    input  wire logic                            end_of_stream,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [cmf_pkg::LINE_W-1:0]      line_number,
    input  wire logic                            is_header,
    input  wire logic [cmf_pkg::COLSEL_W-1:0]    column_total,
    input  wire logic                            column_out_of_range,
    input  wire logic                            field_matches,
    output int                                   mismatch_count,
    output int                                   outstanding
);

    localparam int KEY_BYTES   = 16;
    localparam int MAX_COLUMNS = 64;

    logic [cmf_pkg::COLSEL_W-1:0]    col_sel;
    logic [cmf_pkg::KEYLEN_W-1:0]    key_len;
    logic [63:0]                     key_lo;
    logic [63:0]                     key_hi;

    logic                            header_done;
    logic                            stopped;
    logic [6:0]                      comma_count;
    logic [cmf_pkg::FIELD_POS_W-1:0] field_position;
    logic                            field_seen;
    logic                            field_closed;
    logic                            still_equal;
    logic                            line_has_bytes;
    logic [cmf_pkg::LINE_W-1:0]      data_lines;

    cmf_pkg::result_t expected_lines [$];
    int               faults;

    function automatic logic [cmf_pkg::KEYLEN_W-1:0] key_span();
        int limit;
        limit = (KEY_BYTES < 16) ? KEY_BYTES : 16;
        return (int'(key_len) < limit) ? key_len : cmf_pkg::KEYLEN_W'(limit);
    endfunction

    function automatic logic [7:0] key_byte(input logic [cmf_pkg::FIELD_POS_W-1:0] pos);
        logic [2:0] lane;
        lane = pos[2:0];
        return pos[3] ? key_hi[8*lane +: 8] : key_lo[8*lane +: 8];
    endfunction

    task automatic clear_line();
        comma_count    = '0;
        field_position = '0;
        field_seen     = 1'b0;
        field_closed   = 1'b0;
        still_equal    = 1'b1;
        line_has_bytes = 1'b0;
    endtask

    task automatic bump_comma();
        if (int'(comma_count) < MAX_COLUMNS - 1)
            comma_count = comma_count + 7'd1;
    endtask

    task automatic close_pending_line();
        cmf_pkg::result_t r;
        logic [7:0]       total;
        logic             present;
        r = '0;
        if (!header_done)
        begin
            total = {1'b0, comma_count} + 8'd1;
            r.is_header = 1'b1;
            r.column_total = total[6:0];
            r.column_out_of_range = (col_sel == '0) || ({1'b0, col_sel} > total);
            header_done = 1'b1;
            if (r.column_out_of_range)
                stopped = 1'b1;
        end
        else
        begin
            present = field_seen || ({1'b0, comma_count} + 8'd1 == {1'b0, col_sel});
            if (data_lines != '1)
                data_lines = data_lines + 1'b1;
            r.line_number = data_lines;
            r.field_matches = present && still_equal && (field_position == key_span());
        end
        expected_lines.push_back(r);
        clear_line();
    endtask

    task automatic absorb_word(input logic [cmf_pkg::TEXT_W-1:0] b, input logic eos);
        if (stopped)
            return;
        if (eos)
        begin
            if (line_has_bytes)
                close_pending_line();
            return;
        end
        if (b == cmf_pkg::CHAR_NEWLINE)
        begin
            close_pending_line();
            return;
        end
        line_has_bytes = 1'b1;
        if (!header_done)
        begin
            if (b == cmf_pkg::CHAR_COMMA)
                bump_comma();
            return;
        end
        if (field_closed)
            return;
        if ({1'b0, comma_count} + 8'd1 == {1'b0, col_sel})
        begin
            field_seen = 1'b1;
            if (b == cmf_pkg::CHAR_COMMA)
                field_closed = 1'b1;
            else
            begin
                if (!(field_position < key_span() && key_byte(field_position) == b))
                    still_equal = 1'b0;
                if (field_position != '1)
                    field_position = field_position + 1'b1;
            end
        end
        else if (b == cmf_pkg::CHAR_COMMA)
        begin
            bump_comma();
        end
    endtask

    task automatic apply_register(input logic [cmf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [cmf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            cmf_pkg::REG_COLUMN_SELECT:  col_sel = data[cmf_pkg::COLSEL_W-1:0];
            cmf_pkg::REG_KEY_LENGTH:     key_len = data[cmf_pkg::KEYLEN_W-1:0];
            cmf_pkg::REG_KEY_BYTES_LOW:  key_lo  = data;
            cmf_pkg::REG_KEY_BYTES_HIGH: key_hi  = data;
            default:                     ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [cmf_pkg::LINE_W-1:0] want,
                                 input logic [cmf_pkg::LINE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmf_pkg::result_t head;
        if (!rst_n)
        begin
            col_sel     = 7'd1;
            key_len     = 5'd1;
            key_lo      = '0;
            key_hi      = '0;
            header_done = 1'b0;
            stopped     = 1'b0;
            data_lines  = '0;
            clear_line();
            expected_lines.delete();
            faults = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("result word with no expectation: line_number %0d", line_number);
                    faults++;
                end
                else
                begin
                    head = expected_lines.pop_front();
                    compare_field("line_number", head.line_number, line_number);
                    compare_field("is_header", head.is_header, is_header);
                    compare_field("column_total", head.column_total, column_total);
                    compare_field("column_out_of_range", head.column_out_of_range,
                                  column_out_of_range);
                    compare_field("field_matches", head.field_matches, field_matches);
                end
            end
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                absorb_word(text_byte, end_of_stream);
            mismatch_count <= faults;
            outstanding    <= expected_lines.size();
        end
    end

endmodule

>>> test/tb_csv_column_match_filter.sv
// Stimulus and verdict for the CSV column match filter.
`timescale 1ns / 100ps

module tb_csv_column_match_filter;

    localparam int RANDOM_ITEMS = 1450;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_TAIL  = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_write     = 1'b0;
    logic [cmf_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [cmf_pkg::TEXT_W-1:0]      text_byte     = '0;
    logic                            end_of_stream = 1'b0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic [cmf_pkg::LINE_W-1:0]      line_number;
    logic                            is_header;
    logic [cmf_pkg::COLSEL_W-1:0]    column_total;
    logic                            column_out_of_range;
    logic                            field_matches;
    int                              mismatch_count;
    int                              outstanding;

    logic                            steady_flow   = 1'b0;
    int                              hold_requests = 0;
    int                              items_sent    = 0;
    logic [7:0]                      key_mem [16];

    always #6 clk = ~clk;

    csv_column_match_filter dut
    (
        .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .text_byte, .end_of_stream,
        .out_valid, .out_stall, .line_number, .is_header,
        .column_total, .column_out_of_range, .field_matches
    );

    cmf_result_checker u_checker
    (
        .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .text_byte, .end_of_stream,
        .out_valid, .out_stall, .line_number, .is_header,
        .column_total, .column_out_of_range, .field_matches,
        .mismatch_count, .outstanding
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == cmf_pkg::CHAR_COMMA || c == cmf_pkg::CHAR_NEWLINE)
            c = 8'h41;
        return c;
    endfunction

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic eos);
        if (!steady_flow)
            pause_sender(pick_gap());
        in_valid      <= 1'b1;
        text_byte     <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    task automatic program_filter(input logic [6:0] col, input logic [4:0] len,
                                  input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write <= 1'b1;
        cfg_index <= cmf_pkg::REG_COLUMN_SELECT;
        cfg_data  <= {junk[63:7], col};
        @(posedge clk);
        cfg_index <= cmf_pkg::REG_KEY_LENGTH;
        cfg_data  <= {junk[63:5], len};
        @(posedge clk);
        cfg_index <= cmf_pkg::REG_KEY_BYTES_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= cmf_pkg::REG_KEY_BYTES_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_key_field(input int span);
        int kind;
        int spot;
        kind = $urandom_range(0, 9);
        if (kind <= 3 || (kind == 6 && span == 0))
        begin
            for (int i = 0; i < span; i++)
                send_word(key_mem[i], 1'b0);
        end
        else if (kind == 4)
        begin
            for (int i = 0; i < span - 1; i++)
                send_word(key_mem[i], 1'b0);
        end
        else if (kind == 5)
        begin
            for (int i = 0; i < span; i++)
                send_word(key_mem[i], 1'b0);
            send_word(text_char(), 1'b0);
        end
        else if (kind == 6)
        begin
            spot = $urandom_range(0, span - 1);
            for (int i = 0; i < span; i++)
                send_word((i == spot) ? key_mem[i] ^ 8'($urandom_range(1, 255)) : key_mem[i],
                          1'b0);
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(17, 36)) send_word(text_char(), 1'b0);
        end
        else if (kind == 9)
        begin
            repeat ($urandom_range(1, 8)) send_word(text_char(), 1'b0);
        end
    endtask

    task automatic send_record(input int col, input int span);
        int fields;
        int ending;
        if (col >= 1 && col <= 64)
        begin
            fields = col + $urandom_range(0, 2);
            if ($urandom_range(0, 5) == 0)
                fields = $urandom_range(0, col - 1);
        end
        else
        begin
            fields = $urandom_range(0, 4);
        end
        for (int f = 1; f <= fields; f++)
        begin
            if (f > 1)
                send_word(cmf_pkg::CHAR_COMMA, 1'b0);
            if (f == col)
                send_key_field(span);
            else
                repeat ((col == 64) ? $urandom_range(0, 1) : $urandom_range(0, 3))
                    send_word(text_char(), 1'b0);
        end
        ending = $urandom_range(0, 19);
        if (ending < 15)
            send_word(cmf_pkg::CHAR_NEWLINE, 1'b0);
        else if (ending < 19)
            send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin : receiver
        int stall_left;
        int held;
        stall_left = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (held != hold_requests)
            begin
                held = hold_requests;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int          phase_start;
        int          budget;
        int          phase;
        int          col;
        int          len;
        int          span;
        logic        wild;
        logic [63:0] lo;
        logic [63:0] hi;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The header is seen only once, so it carries enough commas to saturate the count.
        program_filter(7'd64, 5'd1, 64'd0, 64'd0);
        for (int c = 0; c < 70; c++)
        begin
            repeat ($urandom_range(0, 2)) send_word(text_char(), 1'b0);
            send_word(cmf_pkg::CHAR_COMMA, 1'b0);
        end
        send_word(cmf_pkg::CHAR_NEWLINE, 1'b0);

        settle();
        program_filter(7'd2, 5'd2, 64'h6261, {$urandom, $urandom});
        send_text("x,ab\n");
        send_text("x,aX\n");
        send_text("\n");
        send_word(8'($urandom_range(0, 255)), 1'b1);
        send_word(8'hFF, 1'b0);
        send_text(",ab");
        send_word(8'($urandom_range(0, 255)), 1'b1);
        send_text("a\n");

        settle();
        program_filter(7'd1, 5'd0, {$urandom, $urandom}, {$urandom, $urandom});
        send_text("\n");
        send_text(",\n");
        send_word(8'h00, 1'b0);
        send_word(cmf_pkg::CHAR_NEWLINE, 1'b0);

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            case (phase % 8)
                0:       col = 1;
                1:       col = $urandom_range(2, 4);
                2:       col = 64;
                3:       col = 0;
                4:       col = (phase == 4) ? 127 : $urandom_range(65, 126);
                5:       col = $urandom_range(1, 6);
                6:       col = $urandom_range(1, 3);
                default: col = $urandom_range(2, 8);
            endcase
            case (phase % 5)
                0:       len = 1;
                1:       len = 16;
                2:       len = 0;
                3:       len = (phase == 3) ? 31 : $urandom_range(17, 30);
                default: len = $urandom_range(2, 15);
            endcase
            wild = (phase % 3 == 2);
            for (int i = 0; i < 16; i++)
                key_mem[i] = wild ? 8'($urandom_range(0, 255)) : text_char();
            for (int i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = key_mem[i];
                hi[8*i +: 8] = key_mem[i + 8];
            end
            span = (len > 16) ? 16 : len;
            steady_flow <= (phase % 4 == 1);
            if (phase == 1)
                hold_requests <= hold_requests + 1;
            program_filter(7'(col), 5'(len), lo, hi);
            budget = (col == 64) ? 300 : 120;
            phase_start = items_sent;
            while (items_sent - phase_start < budget && items_sent < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_record(col, span);
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> csv_column_match_filter.f
hdl/cmf_pkg.sv
hdl/cmf_front.sv
hdl/cmf_queue.sv
hdl/cmf_back.sv
hdl/csv_column_match_filter.sv
test/cmf_result_checker.sv
test/tb_csv_column_match_filter.sv
